[hdl/blist_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blist_pkg: shared types and codes of the bounded array list
// Request and error codes, field widths, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package blist_pkg;

  localparam int MODE_W = 4;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;
  localparam int ERR_W  = 2;

  localparam logic [MODE_W-1:0] MODE_READ       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_ERASE      = 4'd3;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd5;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_LAST       = 4'd8;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd9;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the request beat
    logic rd_start;  // read the addressed word
    logic rd_cap;    // hold the word just read
    logic ptr_init;  // set the shift pointer to its first source
    logic rd_ptr;    // read the word under the shift pointer
    logic wr_shift;  // write that word one place up or down
    logic ptr_step;  // advance the shift pointer
    logic finish;    // commit the count and load the result register
  } blist_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read;   // request returns a stored word
    logic shift_up;    // words must move up to open a gap
    logic shift_down;  // words must move down to close a gap
    logic shift_end;   // pointer is at the final source word
  } blist_sts_t;

endpackage

[hdl/blist_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blist_dp: datapath of the bounded array list
// Word memory, length count, request and result registers, request
// decoding and the shift pointer that moves words one place at a time.
// ----------------------------------------------------------------------------
module blist_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  blist_pkg::blist_cmd_t                cmd_i,
  output blist_pkg::blist_sts_t                sts_o,
  input  logic        [blist_pkg::MODE_W-1:0]  mode_i,
  input  logic        [blist_pkg::POS_W-1:0]   position_i,
  input  logic signed [blist_pkg::DATA_W-1:0]  value_i,
  output logic signed [blist_pkg::DATA_W-1:0]  read_value_o,
  output logic        [blist_pkg::LEN_W-1:0]   new_length_o,
  output logic        [blist_pkg::ERR_W-1:0]   error_o
);
  import blist_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic        [MODE_W-1:0] mode_q;
  logic        [POS_W-1:0]  pos_q;
  logic signed [DATA_W-1:0] val_q;
  logic        [CW-1:0]     count_q;
  logic        [CW-1:0]     count_d;
  logic        [AW-1:0]     ptr_q;
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] hold_q;
  logic signed [DATA_W-1:0] res_val_q;
  logic        [LEN_W-1:0]  res_len_q;
  logic        [ERR_W-1:0]  res_err_q;

  logic [CMPW-1:0]  pos_c;
  logic [CMPW-1:0]  cnt_c;
  logic [CMPW-1:0]  base_c;
  logic [AW-1:0]    base_a;
  logic [AW-1:0]    last_a;
  logic [ERR_W-1:0] err;
  logic             need_read;
  logic             ins;
  logic             ers;
  logic             wr_only;
  logic             clr;
  logic             is_full;
  logic             is_empty;
  logic             pos_lt;
  logic             pos_le;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic signed [DATA_W-1:0] mem_wd;
  logic [AW-1:0]    mem_ra;

  assign pos_c    = CMPW'(pos_q);
  assign cnt_c    = CMPW'(count_q);
  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign pos_lt   = (pos_c < cnt_c);
  assign pos_le   = (pos_c <= cnt_c);

  // Decode the held request against the current length
  always_comb begin
    err       = ERR_OK;
    need_read = 1'b0;
    ins       = 1'b0;
    ers       = 1'b0;
    wr_only   = 1'b0;
    clr       = 1'b0;
    base_c    = pos_c;
    unique case (mode_q)
      MODE_READ: begin
        if (!pos_lt) err = ERR_RANGE;
        else need_read = 1'b1;
      end
      MODE_WRITE: begin
        if (!pos_lt) err = ERR_RANGE;
        else wr_only = 1'b1;
      end
      MODE_INSERT: begin
        if (!pos_le) err = ERR_RANGE;
        else if (is_full) err = ERR_FULL;
        else ins = 1'b1;
      end
      MODE_ERASE: begin
        if (!pos_lt) err = ERR_RANGE;
        else ers = 1'b1;
      end
      MODE_PUSH_BACK: begin
        base_c = cnt_c;
        if (is_full) err = ERR_FULL;
        else ins = 1'b1;
      end
      MODE_PUSH_FRONT: begin
        base_c = '0;
        if (is_full) err = ERR_FULL;
        else ins = 1'b1;
      end
      MODE_POP_BACK: begin
        base_c = cnt_c - CMPW'(1);
        if (is_empty) err = ERR_EMPTY;
        else begin
          need_read = 1'b1;
          ers       = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        base_c = '0;
        if (is_empty) err = ERR_EMPTY;
        else begin
          need_read = 1'b1;
          ers       = 1'b1;
        end
      end
      MODE_LAST: begin
        base_c = cnt_c - CMPW'(1);
        if (is_empty) err = ERR_EMPTY;
        else need_read = 1'b1;
      end
      MODE_CLEAR: clr = 1'b1;
      default: ;
    endcase
  end

  assign base_a = AW'(base_c);
  assign last_a = AW'(cnt_c - CMPW'(1));

  assign sts_o.need_read  = need_read;
  assign sts_o.shift_up   = ins && (cnt_c > base_c);
  assign sts_o.shift_down = ers && ((base_c + CMPW'(1)) < cnt_c);
  assign sts_o.shift_end  = ins ? (ptr_q == base_a) : (ptr_q == last_a);

  always_comb begin
    if (clr) count_d = '0;
    else if (ins) count_d = count_q + CW'(1);
    else if (ers) count_d = count_q - CW'(1);
    else count_d = count_q;
  end

  // Memory ports: one write, one registered read
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ins ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
    mem_wd = rdata_q;
    mem_ra = cmd_i.rd_ptr ? ptr_q : base_a;
    if (cmd_i.wr_shift) begin
      mem_we = 1'b1;
    end else if (cmd_i.finish && (ins || wr_only)) begin
      mem_we = 1'b1;
      mem_wa = base_a;
      mem_wd = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  // Request, pointer and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    if (cmd_i.rd_cap) begin
      hold_q <= rdata_q;
    end
    if (cmd_i.ptr_init) begin
      ptr_q <= ins ? last_a : AW'(base_c + CMPW'(1));
    end else if (cmd_i.ptr_step) begin
      ptr_q <= ins ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
    end
    if (cmd_i.finish) begin
      res_val_q <= need_read ? hold_q : '0;
      res_len_q <= LEN_W'(count_d);
      res_err_q <= err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish) begin
      count_q <= count_d;
    end
  end

  assign read_value_o = res_val_q;
  assign new_length_o = res_len_q;
  assign error_o      = res_err_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("length count beyond capacity");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (err != ERR_OK) |=> $stable(count_q))
    else $error("failing request changed the length");

  a_fail_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (err != ERR_OK) |=> (res_val_q == '0))
    else $error("failing request returned a word");

  a_shift_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_shift |-> (ins != ers))
    else $error("shift write without a single direction");
`endif

endmodule

[hdl/blist_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blist_ctrl: controller of the bounded array list
// Sequences one request through check, read, word shift and finish,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module blist_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  blist_pkg::blist_sts_t sts_i,
  output blist_pkg::blist_cmd_t cmd_o
);
  import blist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_FIN
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   slot_busy;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_busy   = out_valid_q && out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.need_read) begin
          cmd_o.rd_start = 1'b1;
          state_d        = S_RD_WAIT;
        end else if (sts_i.shift_up || sts_i.shift_down) begin
          cmd_o.ptr_init = 1'b1;
          state_d        = S_SH_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RD_WAIT: begin
        cmd_o.rd_cap = 1'b1;
        if (sts_i.shift_down) begin
          cmd_o.ptr_init = 1'b1;
          state_d        = S_SH_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SH_RD: begin
        cmd_o.rd_ptr = 1'b1;
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        if (sts_i.shift_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o.ptr_step = 1'b1;
          state_d        = S_SH_RD;
        end
      end
      S_FIN: begin
        if (!slot_busy) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q && (state_q == S_IDLE))
    else $error("finish did not present a result");

  a_shift_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_WR) |-> (sts_i.shift_up || sts_i.shift_down))
    else $error("shift step without words to move");

  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_WAIT) |-> sts_i.need_read && !sts_i.shift_up)
    else $error("read wait for a request that reads nothing");
`endif

endmodule

[hdl/bounded_array_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list: ordered list of signed 32-bit words with a length
// Read, write, insert, erase, push, pop, last and clear on a packed list
// of up to CAPACITY words, one result beat for each request beat.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: in_valid_i / in_stall_o with mode_i, position_i and
//   value_i. A beat is taken when in_valid_i is high and in_stall_o low.
//   Result channel: out_valid_o / out_stall_i with read_value_o,
//   new_length_o and error_o, one result beat per request beat, in order.
//   Timing: the block works on one request at a time. A request passes
//   through check, a read wait when a read, last or pop succeeds, a read
//   step and a write step for every word moved by insert, push front,
//   erase or pop front, and finally finish. The word memory sets this:
//   its read port is registered, so every moved word is first read and
//   then written. At most CAPACITY - 1 words move in one request.
//   Stall: the result sits in an output register, so a new request is
//   taken while the previous result still waits; the block holds in its
//   finish step only if that result has not been taken by then.
//   Reset: clears the length and both handshakes. The word memory is not
//   cleared; only words below the length are ever read.
// ----------------------------------------------------------------------------
module bounded_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [blist_pkg::MODE_W-1:0]  mode_i,
  input  logic        [blist_pkg::POS_W-1:0]   position_i,
  input  logic signed [blist_pkg::DATA_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [blist_pkg::DATA_W-1:0]  read_value_o,
  output logic        [blist_pkg::LEN_W-1:0]   new_length_o,
  output logic        [blist_pkg::ERR_W-1:0]   error_o
);
  import blist_pkg::*;

  // Command and status bundles between sequencer and datapath
  blist_cmd_t cmd;
  blist_sts_t sts;

  // Sequencer: handshakes and step order for each request
  blist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: word memory, length, request decode and result register
  blist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .read_value_o (read_value_o),
    .new_length_o (new_length_o),
    .error_o      (error_o)
  );

endmodule

[sim/blist_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blist_checker: result predictor and comparator for the bounded array list
// Watches the request and result channels, keeps its own copy of the list,
// queues the expected result of every accepted request beat and compares
// each accepted result beat, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module blist_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic        [blist_pkg::MODE_W-1:0]  mode_i,
  input  logic        [blist_pkg::POS_W-1:0]   position_i,
  input  logic signed [blist_pkg::DATA_W-1:0]  value_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [blist_pkg::DATA_W-1:0]  read_value_i,
  input  logic        [blist_pkg::LEN_W-1:0]   new_length_i,
  input  logic        [blist_pkg::ERR_W-1:0]   error_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import blist_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic        [LEN_W-1:0]  new_length;
    logic        [ERR_W-1:0]  error;
  } list_result_t;

  logic signed [DATA_W-1:0] words_q [CAPACITY];
  int unsigned              count_q;
  list_result_t             due_results [$];
  int                       fail_n = 0;
  int                       n_due;

  assign fail_count_o = fail_n;
  assign pending_o    = n_due;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_n++;
  endtask

  // Apply one request to the local list and work out its result.
  task automatic apply_request(input logic [MODE_W-1:0] mode,
                               input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val,
                               output list_result_t res);
    int unsigned p;
    int unsigned j;
    p = pos;
    res.read_value = '0;
    res.error      = ERR_OK;
    case (mode)
      MODE_READ: begin
        if (p >= count_q) res.error = ERR_RANGE;
        else res.read_value = words_q[p];
      end
      MODE_WRITE: begin
        if (p >= count_q) res.error = ERR_RANGE;
        else words_q[p] = val;
      end
      MODE_INSERT: begin
        if (p > count_q) res.error = ERR_RANGE;
        else if (count_q >= CAPACITY) res.error = ERR_FULL;
        else begin
          for (j = count_q; j > p; j--) words_q[j] = words_q[j-1];
          words_q[p] = val;
          count_q++;
        end
      end
      MODE_ERASE: begin
        if (p >= count_q) res.error = ERR_RANGE;
        else begin
          for (j = p; j + 1 < count_q; j++) words_q[j] = words_q[j+1];
          count_q--;
        end
      end
      MODE_PUSH_BACK: begin
        if (count_q >= CAPACITY) res.error = ERR_FULL;
        else begin
          words_q[count_q] = val;
          count_q++;
        end
      end
      MODE_PUSH_FRONT: begin
        if (count_q >= CAPACITY) res.error = ERR_FULL;
        else begin
          for (j = count_q; j > 0; j--) words_q[j] = words_q[j-1];
          words_q[0] = val;
          count_q++;
        end
      end
      MODE_POP_BACK: begin
        if (count_q == 0) res.error = ERR_EMPTY;
        else begin
          count_q--;
          res.read_value = words_q[count_q];
        end
      end
      MODE_POP_FRONT: begin
        if (count_q == 0) res.error = ERR_EMPTY;
        else begin
          res.read_value = words_q[0];
          for (j = 0; j + 1 < count_q; j++) words_q[j] = words_q[j+1];
          count_q--;
        end
      end
      MODE_LAST: begin
        if (count_q == 0) res.error = ERR_EMPTY;
        else res.read_value = words_q[count_q-1];
      end
      MODE_CLEAR: count_q = 0;
      default: ;
    endcase
    res.new_length = LEN_W'(count_q);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t res;
    list_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) words_q[i] = '0;
      count_q = 0;
      due_results.delete();
      n_due = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        apply_request(mode_i, position_i, value_i, res);
        due_results.insert(due_results.size(), res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (read_value_i !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      read_value_i, want.read_value));
          if (new_length_i !== want.new_length)
            report_mismatch($sformatf("new_length got %0d want %0d",
                                      new_length_i, want.new_length));
          if (error_i !== want.error)
            report_mismatch($sformatf("error got %0d want %0d",
                                      error_i, want.error));
        end
      end
      n_due = due_results.size();
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the bounded array list testbench
// Drives request beats (a short directed run, then phases that grow, shrink
// and churn the list), stalls the result side at random, and leaves all
// prediction and comparison to the checker. Gives the verdict at the end.
// ----------------------------------------------------------------------------
module tb;
  import blist_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int PHASE_LEN      = 120;
  // The slowest request is a pop front that moves CAPACITY-1 words; add the
  // longest stall and gap, then take it several times over.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 150;

  localparam int PHASE_GROW   = 0;
  localparam int PHASE_MIXED  = 1;
  localparam int PHASE_SHRINK = 2;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic        [MODE_W-1:0]  mode = MODE_READ;
  logic        [POS_W-1:0]   position = '0;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  read_value;
  logic        [LEN_W-1:0]   new_length;
  logic        [ERR_W-1:0]   error;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int stall_left = 0;
  int list_len = 0;   // rough length, used only to aim positions
  bit calm = 1'b0;    // while set, neither side idles

  always #2 clk = ~clk;

  bounded_array_list #(.CAPACITY(CAPACITY)) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .position_i   (position),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_o (read_value),
    .new_length_o (new_length),
    .error_o      (error)
  );

  blist_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .position_i   (position),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_i (read_value),
    .new_length_i (new_length),
    .error_i      (error),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Flip between calm stretches and idling stretches now and then.
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Result side: hold stall for a random run of cycles, then release it.
  always @(negedge clk) begin
    int g;
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      g = pick_gap();
      out_stall = (g > 0);
      stall_left = (g > 0) ? g - 1 : 0;
    end
  end

  // Watchdog: stop the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("tb NOT OK");
          $finish;
        end
      end
    end
  end

  // Present one request beat, hold it until taken, then idle for a random gap, often none.
  task automatic send_req(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                          input logic signed [DATA_W-1:0] v);
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    mode     = m;
    position = p;
    value    = v;
    do @(posedge clk); while (in_stall);
    // Track the length roughly so that positions land in range.
    case (m)
      MODE_INSERT: if (p <= list_len && list_len < CAPACITY) list_len++;
      MODE_ERASE: if (p < list_len) list_len--;
      MODE_PUSH_BACK, MODE_PUSH_FRONT: if (list_len < CAPACITY) list_len++;
      MODE_POP_BACK, MODE_POP_FRONT: if (list_len > 0) list_len--;
      MODE_CLEAR: list_len = 0;
      default: ;
    endcase
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Position: mostly inside the list, sometimes anywhere the field allows.
  function automatic logic [POS_W-1:0] pick_pos(input int limit);
    if (limit <= 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 127));
    return POS_W'($urandom_range(0, limit - 1));
  endfunction

  // Word: mostly random, sometimes one of the extremes.
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One random request, biased by the phase of the run.
  task automatic send_random(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_req(MODE_W'($urandom_range(10, 15)), POS_W'($urandom), $urandom);
    end else if (phase == PHASE_GROW && r < 87) begin
      case ($urandom_range(0, 2))
        0: send_req(MODE_PUSH_BACK, POS_W'($urandom), pick_word());
        1: send_req(MODE_PUSH_FRONT, POS_W'($urandom), pick_word());
        default: send_req(MODE_INSERT, pick_pos(list_len + 1), pick_word());
      endcase
    end else if (phase == PHASE_SHRINK && r < 87) begin
      case ($urandom_range(0, 2))
        0: send_req(MODE_POP_BACK, POS_W'($urandom), $urandom);
        1: send_req(MODE_POP_FRONT, POS_W'($urandom), $urandom);
        default: send_req(MODE_ERASE, pick_pos(list_len), $urandom);
      endcase
    end else if (phase == PHASE_MIXED && r < 3) begin
      send_req(MODE_CLEAR, POS_W'($urandom), $urandom);
    end else begin
      case ($urandom_range(0, 8))
        0: send_req(MODE_READ, pick_pos(list_len), $urandom);
        1: send_req(MODE_WRITE, pick_pos(list_len), pick_word());
        2: send_req(MODE_INSERT, pick_pos(list_len + 1), pick_word());
        3: send_req(MODE_ERASE, pick_pos(list_len), $urandom);
        4: send_req(MODE_PUSH_BACK, POS_W'($urandom), pick_word());
        5: send_req(MODE_PUSH_FRONT, POS_W'($urandom), pick_word());
        6: send_req(MODE_POP_BACK, POS_W'($urandom), $urandom);
        7: send_req(MODE_POP_FRONT, POS_W'($urandom), $urandom);
        default: send_req(MODE_LAST, POS_W'($urandom), $urandom);
      endcase
    end
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty list: indexed requests are out of range, end requests empty.
    send_req(MODE_READ,      7'd0,   32'sd0);
    send_req(MODE_POP_BACK,  7'd0,   32'sd0);
    send_req(MODE_POP_FRONT, 7'd0,   32'sd0);
    send_req(MODE_LAST,      7'd0,   32'sd0);
    send_req(MODE_ERASE,     7'd0,   32'sd0);
    send_req(MODE_WRITE,     7'd0,   32'sd5);
    send_req(MODE_INSERT,    7'd1,   32'sd9);
    // Insert at the end position appends; push at both ends with extremes.
    send_req(MODE_INSERT,     7'd0, 32'h7FFF_FFFF);
    send_req(MODE_PUSH_BACK,  7'd0, 32'h8000_0000);
    send_req(MODE_PUSH_FRONT, 7'd0, 32'hFFFF_FFFF);
    send_req(MODE_INSERT,     7'd3, 32'h1234_5678);
    send_req(MODE_INSERT,     7'd1, 32'h0000_0000);
    // Reads at, past and far past the end.
    send_req(MODE_READ,  7'd127, 32'sd0);
    send_req(MODE_READ,  7'd4,   32'sd0);
    send_req(MODE_READ,  7'd5,   32'sd0);
    send_req(MODE_WRITE, 7'd2,   32'hA5A5_A5A5);
    send_req(MODE_LAST,  7'd0,   32'sd0);
    send_req(MODE_ERASE, 7'd2,   32'sd0);
    send_req(MODE_ERASE, 7'd4,   32'sd0);
    send_req(MODE_POP_BACK,  7'd0, 32'sd0);
    send_req(MODE_POP_FRONT, 7'd0, 32'sd0);
    // Unused modes change nothing.
    send_req(MODE_W'(10), 7'd0,   32'sd1);
    send_req(MODE_W'(15), 7'd127, 32'hFFFF_FFFF);
    send_req(MODE_READ,   7'd0,   32'sd0);
    send_req(MODE_CLEAR,  7'd0,   32'sd0);
    send_req(MODE_READ,   7'd0,   32'sd0);

    // Random part: grow to full, churn, shrink to empty, churn, and again.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i / PHASE_LEN) % 4)
        0: phase = PHASE_GROW;
        2: phase = PHASE_SHRINK;
        default: phase = PHASE_MIXED;
      endcase
      send_random(phase);
    end

    @(negedge clk);
    in_valid = 1'b0;

    // Drain: wait for every outstanding result, then let the block settle.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
